### rtl/core/sus_pkg.sv
// Shared types and constants for the sorted unique set insertion core.
// Used by every module under rtl/core; depends on nothing else.
package sus_pkg;

  // Fixed widths of the transaction fields.
  localparam int KIND_W      = 2;
  localparam int IN_VALUE_W  = 16;
  localparam int IN_INDEX_W  = 8;
  localparam int COUNT_OUT_W = 9;
  localparam int READ_W      = 16;

  // Operation codes carried by in_kind.
  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_READ   = 2'd1,
    KIND_CLEAR  = 2'd2
  } kind_t;

  // Status gathered from the row of cells for the current transaction.
  typedef struct packed {
    logic              any_eq;
    logic [READ_W-1:0] rd_data;
  } sus_row_stat_t;

endpackage

### rtl/core/sus_cell.sv
// One storage cell of the sorted table: holds a single entry and moves it up.
// Depends on sus_pkg.
module sus_cell
  import sus_pkg::*;
#(
  parameter int CELL_IDX   = 0,
  parameter int VALUE_BITS = 16,
  parameter int CNT_W      = 9,
  parameter int CMP_W      = 9
) (
  input  logic                  clk,
  input  logic                  shift_en,
  input  logic [VALUE_BITS-1:0] ins_value,
  input  logic [CNT_W-1:0]      count,
  input  logic [CMP_W-1:0]      rd_index,
  input  logic                  prev_gt,
  input  logic [VALUE_BITS-1:0] prev_entry,
  output logic                  gt,
  output logic                  eq,
  output logic [VALUE_BITS-1:0] entry,
  output logic [READ_W-1:0]     rd_data
);

  logic [VALUE_BITS-1:0] entry_r;
  logic                  occupied;
  logic                  rd_hit;

  // The cell holds a live entry when its position is below the count.
  assign occupied = count > CNT_W'(CELL_IDX);
  assign gt       = occupied && (entry_r > ins_value);
  assign eq       = occupied && (entry_r == ins_value);
  assign entry    = entry_r;

  // Read port: only the addressed cell drives non-zero data.
  assign rd_hit  = rd_index == CMP_W'(CELL_IDX);
  assign rd_data = rd_hit ? READ_W'(entry_r) : '0;

  // On an insert, larger entries move up one place and the new value lands
  // in the first cell whose entry is larger or which is empty.
  always_ff @(posedge clk) begin
    if (shift_en) begin
      if (prev_gt) begin
        entry_r <= prev_entry;
      end else if (gt || !occupied) begin
        entry_r <= ins_value;
      end
    end
  end

endmodule

### rtl/core/sus_cell_row.sv
// Row of sus_cell instances chained by position, with match and read reduction.
// Depends on sus_pkg and sus_cell.
module sus_cell_row
  import sus_pkg::*;
#(
  parameter int TABLE_DEPTH = 256,
  parameter int VALUE_BITS  = 16,
  parameter int CNT_W       = 9,
  parameter int CMP_W       = 9
) (
  input  logic                  clk,
  input  logic                  shift_en,
  input  logic [VALUE_BITS-1:0] ins_value,
  input  logic [CNT_W-1:0]      count,
  input  logic [CMP_W-1:0]      rd_index,
  output sus_row_stat_t         stat
);

  logic [TABLE_DEPTH:0]                      gt_chain;
  logic [TABLE_DEPTH:0][VALUE_BITS-1:0]      ent_chain;
  logic [TABLE_DEPTH-1:0]                    eq_vec;
  logic [TABLE_DEPTH-1:0][READ_W-1:0]        rd_vec;

  // Nothing stands below the first cell.
  assign gt_chain[0]  = 1'b0;
  assign ent_chain[0] = '0;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    sus_cell #(
      .CELL_IDX   (i),
      .VALUE_BITS (VALUE_BITS),
      .CNT_W      (CNT_W),
      .CMP_W      (CMP_W)
    ) u_cell (
      .clk        (clk),
      .shift_en   (shift_en),
      .ins_value  (ins_value),
      .count      (count),
      .rd_index   (rd_index),
      .prev_gt    (gt_chain[i]),
      .prev_entry (ent_chain[i]),
      .gt         (gt_chain[i+1]),
      .eq         (eq_vec[i]),
      .entry      (ent_chain[i+1]),
      .rd_data    (rd_vec[i])
    );
  end

  // Combine the per-cell match flags and read data.
  always_comb begin
    stat.any_eq  = |eq_vec;
    stat.rd_data = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      stat.rd_data = stat.rd_data | rd_vec[i];
    end
  end

endmodule

### rtl/core/sorted_unique_set_insert_core.sv
// An accepted transaction's result is registered and offered the next cycle.
// Throughput: one transaction per cycle while results are taken; each insert
// is placed by the row of compare-and-shift cells, with one output register.
// Reset: rst_n (synchronous, active low) empties the table and drops any
// pending result; entry storage itself is not cleared.
// Depends on sus_pkg and sus_cell_row.
module sorted_unique_set_insert_core
  import sus_pkg::*;
#(
  parameter int TABLE_DEPTH = 256,
  parameter int VALUE_BITS  = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [KIND_W-1:0]      in_kind,
  input  logic [IN_VALUE_W-1:0]  in_value,
  input  logic [IN_INDEX_W-1:0]  in_index,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   out_was_new,
  output logic                   out_was_present,
  output logic                   out_full_drop,
  output logic [COUNT_OUT_W-1:0] out_entry_count,
  output logic [READ_W-1:0]      out_read_value,
  output logic                   out_bad_index
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int CMP_W = (CNT_W > IN_INDEX_W) ? CNT_W : IN_INDEX_W;

  logic [CNT_W-1:0]       count_r, count_nxt;
  logic                   out_valid_r;
  logic                   was_new_r, was_present_r, full_drop_r, bad_index_r;
  logic [COUNT_OUT_W-1:0] entry_count_r;
  logic [READ_W-1:0]      read_value_r;

  logic                   accept;
  logic                   shift_en;
  logic                   table_full;
  logic [VALUE_BITS-1:0]  ins_value;
  logic [CMP_W-1:0]       idx_ext;
  logic                   was_new, was_present, full_drop, bad_index;
  logic [READ_W-1:0]      read_value;
  sus_row_stat_t          row_stat;

  // The output register frees up when its result is taken.
  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;

  assign ins_value  = VALUE_BITS'(in_value);
  assign idx_ext    = CMP_W'(in_index);
  assign table_full = count_r == CNT_W'(TABLE_DEPTH);

  sus_cell_row #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .VALUE_BITS  (VALUE_BITS),
    .CNT_W       (CNT_W),
    .CMP_W       (CMP_W)
  ) u_row (
    .clk       (clk),
    .shift_en  (shift_en),
    .ins_value (ins_value),
    .count     (count_r),
    .rd_index  (idx_ext),
    .stat      (row_stat)
  );

  // Operation decode and the result of the current transaction.
  always_comb begin
    was_new     = 1'b0;
    was_present = 1'b0;
    full_drop   = 1'b0;
    bad_index   = 1'b0;
    read_value  = '0;
    count_nxt   = count_r;
    unique case (kind_t'(in_kind))
      KIND_INSERT: begin
        if (row_stat.any_eq) begin
          was_present = 1'b1;
        end else if (table_full) begin
          full_drop = 1'b1;
        end else begin
          was_new   = 1'b1;
          count_nxt = count_r + 1'b1;
        end
      end
      KIND_READ: begin
        if (idx_ext < CMP_W'(count_r)) begin
          read_value = row_stat.rd_data;
        end else begin
          bad_index = 1'b1;
        end
      end
      KIND_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  assign shift_en = accept && was_new;

  // Control state: entry count and result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r <= count_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (accept) begin
      was_new_r     <= was_new;
      was_present_r <= was_present;
      full_drop_r   <= full_drop;
      bad_index_r   <= bad_index;
      read_value_r  <= read_value;
      entry_count_r <= COUNT_OUT_W'(count_nxt);
    end
  end

  assign out_was_new     = was_new_r;
  assign out_was_present = was_present_r;
  assign out_full_drop   = full_drop_r;
  assign out_bad_index   = bad_index_r;
  assign out_read_value  = read_value_r;
  assign out_entry_count = entry_count_r;

  // At most one outcome flag is raised per result.
  a_one_outcome: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $onehot0({was_new_r, was_present_r, full_drop_r, bad_index_r}))
    else $error("more than one outcome flag set");

  // A stored insert grows the count by exactly one.
  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    shift_en |=> count_r == $past(count_r) + 1'b1)
    else $error("count did not grow after insert");

  // A clear empties the table.
  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_kind == KIND_CLEAR)) |=> count_r == '0)
    else $error("count not zero after clear");

endmodule
